### rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// shared widths and constants of the huffman code builder
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int NUM_SYMBOLS = 16;
  localparam int FREQ_BITS   = 20;
  localparam int NODE_SLOTS  = 2 * NUM_SYMBOLS - 1;
  localparam int NODE_BITS   = $clog2(NODE_SLOTS + 1);
  localparam int LEAF_BITS   = $clog2(NUM_SYMBOLS);
  localparam int WEIGHT_BITS = FREQ_BITS + $clog2(NUM_SYMBOLS) + 1;
  localparam int SYM_BITS    = 8;
  localparam int FREQ_PORT   = 20;
  localparam int CODE_BITS   = 15;
  localparam int LEN_BITS    = 4;

  typedef logic [SYM_BITS-1:0]    sym_t;
  typedef logic [FREQ_PORT-1:0]   freq_t;
  typedef logic [CODE_BITS-1:0]   code_t;
  typedef logic [LEN_BITS-1:0]    len_t;
  typedef logic [NODE_BITS-1:0]   node_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;

endpackage

### rtl/hcb_if.sv
// ----------------------------------------------------------------------------
// hcb_entry_if / hcb_code_if
// valid/ready channels for table entries and emitted codes
// ----------------------------------------------------------------------------
interface hcb_entry_if;
  logic                valid;
  logic                ready;
  hcb_pkg::sym_t       symbol;
  hcb_pkg::freq_t      frequency;
  logic                last_entry;

  modport source (output valid, symbol, frequency, last_entry, input ready);
  modport sink   (input valid, symbol, frequency, last_entry, output ready);
endinterface

interface hcb_code_if;
  logic                valid;
  logic                ready;
  hcb_pkg::sym_t       out_symbol;
  hcb_pkg::code_t      code_bits;
  hcb_pkg::len_t       code_length;
  logic                status;
  logic                last_code;

  modport source (output valid, out_symbol, code_bits, code_length, status, last_code,
                  input ready);
  modport sink   (input valid, out_symbol, code_bits, code_length, status, last_code,
                  output ready);
endinterface

### rtl/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// loads (symbol, frequency) entries, builds a huffman tree with one shared
// min-scan compare unit, then walks each leaf to the root to emit its code
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  entry    | in  | symbol, frequency, last_entry
//  code     | out | out_symbol, code_bits, code_length, status, last_code
//
//  an entry is taken whenever valid meets ready; ready is high only while loading
//  after the last entry, each merge takes two scans over the nodes so far,
//  all through the single weight compare unit
//  each code then walks from its leaf up the parents and is loaded into the output register
//  a stalled code holds in the output register; no clearing pass after reset
// ----------------------------------------------------------------------------
module huffman_code_builder (
  input  logic clk,
  input  logic rst,
  hcb_entry_if.sink  entry,
  hcb_code_if.source code
);
  import hcb_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SCAN_A, ST_SCAN_B, ST_WALK, ST_EMIT
  } state_t;

  state_t  state;
  sym_t    leaf_symbols [NUM_SYMBOLS];
  weight_t node_weights [NODE_SLOTS];
  node_t   node_parent  [NODE_SLOTS];
  logic    node_is_right[NODE_SLOTS];
  logic    node_merged  [NODE_SLOTS];
  node_t   entry_count;
  node_t   root_node;
  logic    overflow_seen;

  node_t   total;
  node_t   scan_idx;
  node_t   best;
  weight_t best_w;
  logic    found;
  node_t   first;
  weight_t first_w;
  node_t   leaf_idx;
  node_t   walk_node;
  code_t   walk_bits;
  len_t    walk_len;

  logic    out_valid;
  sym_t    out_symbol;
  code_t   out_bits;
  len_t    out_len;
  logic    out_status;
  logic    out_last;

  logic    take;
  logic    room;
  logic    better;
  node_t   count_next;
  node_t   total_next;
  node_t   leaf_next;

  assign take       = entry.valid && entry.ready;
  assign room       = entry_count < node_t'(NUM_SYMBOLS);
  assign count_next = room ? entry_count + node_t'(1) : entry_count;
  assign total_next = total + node_t'(1);
  assign leaf_next  = leaf_idx + node_t'(1);
  // shared compare unit: live node lighter than the best so far
  assign better     = !node_merged[scan_idx] && (!found || node_weights[scan_idx] < best_w);

  assign entry.ready      = (state == ST_LOAD);
  assign code.valid       = out_valid;
  assign code.out_symbol  = out_symbol;
  assign code.code_bits   = out_bits;
  assign code.code_length = out_len;
  assign code.status      = out_status;
  assign code.last_code   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      entry_count   <= '0;
      root_node     <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      for (int n = 0; n < NODE_SLOTS; n++) node_merged[n] <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (take) begin
            if (room) begin
              leaf_symbols[entry_count[LEAF_BITS-1:0]] <= entry.symbol;
              node_weights[entry_count] <= WEIGHT_BITS'(entry.frequency[FREQ_BITS-1:0]);
              node_merged[entry_count]  <= 1'b0;
            end else begin
              overflow_seen <= 1'b1;
            end
            entry_count <= count_next;
            if (entry.last_entry) begin
              total    <= count_next;
              scan_idx <= '0;
              found    <= 1'b0;
              state    <= ST_SCAN_A;
            end
          end
        end
        ST_SCAN_A: begin
          if (scan_idx == total) begin
            if (!found) begin
              root_node <= total - node_t'(1);
              leaf_idx  <= '0;
              walk_node <= '0;
              walk_bits <= '0;
              walk_len  <= '0;
              state     <= ST_WALK;
            end else begin
              node_merged[best] <= 1'b1;
              first    <= best;
              first_w  <= best_w;
              scan_idx <= '0;
              found    <= 1'b0;
              state    <= ST_SCAN_B;
            end
          end else begin
            if (better) begin
              best   <= scan_idx;
              best_w <= node_weights[scan_idx];
              found  <= 1'b1;
            end
            scan_idx <= scan_idx + node_t'(1);
          end
        end
        ST_SCAN_B: begin
          if (scan_idx == total) begin
            if (!found) begin
              node_merged[first] <= 1'b0;
              root_node <= total - node_t'(1);
              leaf_idx  <= '0;
              walk_node <= '0;
              walk_bits <= '0;
              walk_len  <= '0;
              state     <= ST_WALK;
            end else begin
              node_merged[best]   <= 1'b1;
              node_parent[first]  <= total;
              node_is_right[first] <= 1'b0;
              node_parent[best]   <= total;
              node_is_right[best] <= 1'b1;
              node_weights[total] <= first_w + best_w;
              node_merged[total]  <= 1'b0;
              total    <= total_next;
              scan_idx <= '0;
              found    <= 1'b0;
              if (total_next == node_t'(NODE_SLOTS)) begin
                root_node <= total;
                leaf_idx  <= '0;
                walk_node <= '0;
                walk_bits <= '0;
                walk_len  <= '0;
                state     <= ST_WALK;
              end else begin
                state <= ST_SCAN_A;
              end
            end
          end else begin
            if (better) begin
              best   <= scan_idx;
              best_w <= node_weights[scan_idx];
              found  <= 1'b1;
            end
            scan_idx <= scan_idx + node_t'(1);
          end
        end
        ST_WALK: begin
          // climb one level per cycle, root branch ends up in the msb
          if (walk_node != root_node && walk_len != len_t'(CODE_BITS)) begin
            walk_bits <= walk_bits | (code_t'(node_is_right[walk_node]) << walk_len);
            walk_len  <= walk_len + len_t'(1);
            walk_node <= node_parent[walk_node];
          end else begin
            out_valid  <= 1'b1;
            out_symbol <= leaf_symbols[leaf_idx[LEAF_BITS-1:0]];
            out_bits   <= walk_bits;
            out_len    <= walk_len;
            out_status <= overflow_seen;
            out_last   <= (leaf_next == entry_count);
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (code.ready) begin
            out_valid <= 1'b0;
            if (leaf_next == entry_count) begin
              entry_count   <= '0;
              overflow_seen <= 1'b0;
              for (int n = 0; n < NODE_SLOTS; n++) node_merged[n] <= 1'b0;
              state <= ST_LOAD;
            end else begin
              leaf_idx  <= leaf_next;
              walk_node <= leaf_next;
              walk_bits <= '0;
              walk_len  <= '0;
              state     <= ST_WALK;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_no_code: assert property (@(posedge clk) disable iff (rst)
    entry.ready |-> !code.valid) else $error("entry ready while a code is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= node_t'(NUM_SYMBOLS)) else $error("entry count beyond capacity");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_A || state == ST_SCAN_B) |-> total < node_t'(NODE_SLOTS))
    else $error("node count beyond node slots");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (code.valid && code.ready && code.last_code) |=> (entry_count == '0 && entry.ready))
    else $error("table not cleared after last code");
`endif

endmodule
